// ----- src/gbc_pkg.sv -----
package gbc_pkg;

  // Field widths
  localparam int RATE_W   = 16;
  localparam int MSUM_W   = 18;
  localparam int THRESH_W = 18;
  localparam int LIMIT_W  = 16;
  localparam int NUM_AXES = 3;

  // APB register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Defaults
  localparam int unsigned CALIB_SAMPLES_DEF = 30;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd20;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;

  typedef logic signed [RATE_W-1:0] rate_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CALIB  = 1'b1
  } op_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_THRESH = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_idx_t;

endpackage

// ----- src/gbc_if.sv -----
interface gbc_in_if import gbc_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  rate_t rate_x;
  rate_t rate_y;
  rate_t rate_z;

  modport source (output valid, operation, rate_x, rate_y, rate_z, input ready);
  modport sink   (input valid, operation, rate_x, rate_y, rate_z, output ready);
endinterface

interface gbc_out_if import gbc_pkg::*; ();
  logic              valid;
  logic              ready;
  rate_t             corrected_x;
  rate_t             corrected_y;
  rate_t             corrected_z;
  logic [MSUM_W-1:0] motion_sum;
  logic              stable;
  logic              settled_once;
  logic              bias_valid;
  logic              calibrating;

  modport source (output valid, corrected_x, corrected_y, corrected_z, motion_sum,
                  stable, settled_once, bias_valid, calibrating, input ready);
  modport sink   (input valid, corrected_x, corrected_y, corrected_z, motion_sum,
                  stable, settled_once, bias_valid, calibrating, output ready);
endinterface

// ----- src/gyro_bias_calib_and_still_detect.sv -----
// Registers: input register, then result register; each item passes through both in order.
// Throughput: one item per cycle unless result.ready holds off the result register;
// while a result waits, the input register refills only if it is empty.
// Bias divide is a reciprocal multiply per axis, done in the cycle of the last
// averaging sample, so the new bias applies to the very next sample.
// Reset (rst, synchronous, active high): all state zero, threshold 20, still limit 100.
module gyro_bias_calib_and_still_detect import gbc_pkg::*; #(
  parameter int unsigned CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  gbc_in_if.sink                sample,
  gbc_out_if.source             result
);

  // Averaging sum and divide-by-constant sizing
  localparam int SUM_W     = RATE_W + $clog2(CALIB_SAMPLES);
  localparam int CNT_W     = $clog2(CALIB_SAMPLES + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] RECIP =
    MULT_W'(((longint'(1) << DIV_SHIFT) + longint'(CALIB_SAMPLES) - 1) /
            longint'(CALIB_SAMPLES));
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);

  // Configuration registers
  logic [THRESH_W-1:0] motion_threshold;
  logic [LIMIT_W-1:0]  still_limit;
  reg_idx_t            reg_sel;

  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold <= THRESH_RESET;
      still_limit      <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_THRESH: motion_threshold <= pwdata[THRESH_W-1:0];
        REG_LIMIT:  still_limit      <= pwdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESH: prdata = APB_DATA_W'(motion_threshold);
      REG_LIMIT:  prdata = APB_DATA_W'(still_limit);
      default:    prdata = '0;
    endcase
  end

  // Pipeline control
  logic  stg_valid;
  op_t   stg_op;
  rate_t stg_rate [NUM_AXES];
  logic  res_valid;
  logic  res_en;
  logic  stg_en;
  logic  work;

  assign res_en       = !res_valid || result.ready;
  assign stg_en       = !stg_valid || res_en;
  assign sample.ready = stg_en;
  assign work         = stg_valid && res_en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (stg_en) begin
      stg_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en && sample.valid) begin
      stg_op      <= sample.operation;
      stg_rate[0] <= sample.rate_x;
      stg_rate[1] <= sample.rate_y;
      stg_rate[2] <= sample.rate_z;
    end
  end

  // Block state
  rate_t                    prev_rate [NUM_AXES];
  rate_t                    bias      [NUM_AXES];
  logic signed [SUM_W-1:0]  calib_sum [NUM_AXES];
  logic                     bias_ok;
  logic [LIMIT_W-1:0]       still_count;
  logic                     stable_flag;
  logic                     settled_flag;
  logic                     calib_active;
  logic [CNT_W-1:0]         calib_count;

  rate_t                    prev_rate_next [NUM_AXES];
  rate_t                    bias_next      [NUM_AXES];
  logic signed [SUM_W-1:0]  calib_sum_next [NUM_AXES];
  logic                     bias_ok_next;
  logic [LIMIT_W-1:0]       still_count_next;
  logic                     stable_flag_next;
  logic                     settled_flag_next;
  logic                     calib_active_next;
  logic [CNT_W-1:0]         calib_count_next;
  rate_t                    cor [NUM_AXES];
  logic [MSUM_W-1:0]        msum;

  // Per-item datapath
  always_comb begin
    logic signed [RATE_W:0]   diff;
    logic [RATE_W-1:0]        adiff [NUM_AXES];
    logic signed [SUM_W-1:0]  acc;
    logic [SUM_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [RATE_W-1:0]        quo;

    prev_rate_next    = prev_rate;
    bias_next         = bias;
    calib_sum_next    = calib_sum;
    bias_ok_next      = bias_ok;
    still_count_next  = still_count;
    stable_flag_next  = stable_flag;
    settled_flag_next = settled_flag;
    calib_active_next = calib_active;
    calib_count_next  = calib_count;
    msum              = '0;
    diff              = '0;
    acc               = '0;
    mag               = '0;
    prod              = '0;
    quo               = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      cor[a]   = '0;
      adiff[a] = '0;
    end

    if (stg_op == OP_CALIB) begin
      // Restart averaging, drop the current bias
      bias_ok_next      = 1'b0;
      calib_active_next = 1'b1;
      calib_count_next  = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        calib_sum_next[a] = '0;
      end
    end else begin
      // Bias removal and change from previous sample
      for (int a = 0; a < NUM_AXES; a++) begin
        cor[a]            = bias_ok ? rate_t'(stg_rate[a] - bias[a]) : stg_rate[a];
        diff              = (RATE_W+1)'(prev_rate[a]) - (RATE_W+1)'(cor[a]);
        adiff[a]          = diff[RATE_W] ? RATE_W'(-diff) : diff[RATE_W-1:0];
        prev_rate_next[a] = cor[a];
      end
      msum = MSUM_W'(adiff[0]) + MSUM_W'(adiff[1]) + MSUM_W'(adiff[2]);

      // Stillness tracking
      if (msum < motion_threshold) begin
        if (still_count != '1) begin
          still_count_next = still_count + 1'b1;
        end
      end else begin
        still_count_next = '0;
        stable_flag_next = 1'b0;
      end
      if (still_count_next > still_limit) begin
        stable_flag_next  = 1'b1;
        settled_flag_next = 1'b1;
      end

      // Averaging; last sample divides by reciprocal multiply, toward zero
      if (calib_active) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          acc               = calib_sum[a] + SUM_W'(cor[a]);
          calib_sum_next[a] = acc;
          mag               = acc[SUM_W-1] ? SUM_W'(-acc) : acc;
          prod              = PROD_W'(mag) * PROD_W'(RECIP);
          quo               = prod[DIV_SHIFT +: RATE_W];
          if (calib_count == CNT_LAST) begin
            bias_next[a] = acc[SUM_W-1] ? rate_t'(-quo) : rate_t'(quo);
          end
        end
        if (calib_count == CNT_LAST) begin
          bias_ok_next      = 1'b1;
          calib_active_next = 1'b0;
          calib_count_next  = '0;
        end else begin
          calib_count_next = calib_count + 1'b1;
        end
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prev_rate[a] <= '0;
        bias[a]      <= '0;
        calib_sum[a] <= '0;
      end
      bias_ok      <= 1'b0;
      still_count  <= '0;
      stable_flag  <= 1'b0;
      settled_flag <= 1'b0;
      calib_active <= 1'b0;
      calib_count  <= '0;
    end else if (work) begin
      prev_rate    <= prev_rate_next;
      bias         <= bias_next;
      calib_sum    <= calib_sum_next;
      bias_ok      <= bias_ok_next;
      still_count  <= still_count_next;
      stable_flag  <= stable_flag_next;
      settled_flag <= settled_flag_next;
      calib_active <= calib_active_next;
      calib_count  <= calib_count_next;
    end
  end

  // Result register
  rate_t             res_cor [NUM_AXES];
  logic [MSUM_W-1:0] res_msum;
  logic              res_stable;
  logic              res_settled;
  logic              res_bias_ok;
  logic              res_calib;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_en) begin
      res_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      res_cor     <= cor;
      res_msum    <= msum;
      res_stable  <= stable_flag_next;
      res_settled <= settled_flag_next;
      res_bias_ok <= bias_ok_next;
      res_calib   <= calib_active_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.corrected_x  = res_cor[0];
  assign result.corrected_y  = res_cor[1];
  assign result.corrected_z  = res_cor[2];
  assign result.motion_sum   = res_msum;
  assign result.stable       = res_stable;
  assign result.settled_once = res_settled;
  assign result.bias_valid   = res_bias_ok;
  assign result.calibrating  = res_calib;

  // Checks
  a_bias_xor_calib: assert property (@(posedge clk) disable iff (rst)
    !(bias_ok && calib_active))
    else $error("bias valid while averaging");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    calib_count <= CNT_LAST)
    else $error("averaging count out of range");

  a_stable_settled: assert property (@(posedge clk) disable iff (rst)
    stable_flag |-> settled_flag)
    else $error("stable without settled");

  a_calib_result: assert property (@(posedge clk) disable iff (rst)
    (work && stg_op == OP_CALIB) |=> (res_valid && res_calib && !res_bias_ok))
    else $error("start-calibration result flags wrong");

endmodule

// ----- verif/testbench.sv -----
module testbench import gbc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_LEN     = CALIB_SAMPLES_DEF;
  localparam int QUIET_LIMIT = 2000;

  // One result transfer, as the block reports it
  typedef struct packed {
    rate_t             cx;
    rate_t             cy;
    rate_t             cz;
    logic [MSUM_W-1:0] msum;
    logic              stable;
    logic              settled;
    logic              bias_valid;
    logic              calibrating;
  } gyro_out_t;

  typedef struct {
    op_t       op;
    rate_t     x;
    rate_t     y;
    rate_t     z;
    bit        typed;
    gyro_out_t want;
  } stim_row_t;

  typedef struct {
    int idle_pct;
    int stall_pct;
    int thresh;
    int limit;
    int n_items;
  } phase_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gbc_in_if  sample_bus ();
  gbc_out_if result_bus ();

  gyro_bias_calib_and_still_detect dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_bus),
    .result  (result_bus)
  );

  // Shadow of the block state and registers
  rate_t               prev_rate [NUM_AXES] = '{default: '0};
  rate_t               bias_reg  [NUM_AXES] = '{default: '0};
  logic                bias_ok    = 1'b0;
  logic [LIMIT_W-1:0]  still_cnt  = '0;
  logic                stable_q   = 1'b0;
  logic                settled_q  = 1'b0;
  logic                calib_on   = 1'b0;
  int                  calib_cnt  = 0;
  int                  calib_acc [NUM_AXES] = '{default: 0};
  logic [THRESH_W-1:0] thresh_cfg = THRESH_RESET;
  logic [LIMIT_W-1:0]  limit_cfg  = LIMIT_RESET;

  gyro_out_t due_readings [$];
  int        mismatches  = 0;
  int        quiet_cycles = 0;
  int        idle_pct    = 0;
  int        stall_pct   = 0;
  stim_row_t directed_rows [11];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bias correction, motion sum, stillness and averaging for one item
  function automatic gyro_out_t correct_and_track(input op_t op, input rate_t rx, ry, rz);
    gyro_out_t         r;
    rate_t             raw [NUM_AXES];
    rate_t             cor [NUM_AXES];
    logic [MSUM_W-1:0] motion;
    int                step;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    cor    = '{default: '0};
    motion = '0;
    if (op == OP_CALIB) begin
      bias_ok   = 1'b0;
      calib_on  = 1'b1;
      calib_cnt = 0;
      calib_acc = '{default: 0};
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cor[a] = bias_ok ? rate_t'(raw[a] - bias_reg[a]) : raw[a];
        step   = int'(prev_rate[a]) - int'(cor[a]);
        motion += MSUM_W'((step < 0) ? -step : step);
        prev_rate[a] = cor[a];
      end
      // saturating still counter
      if (motion < thresh_cfg) begin
        if (still_cnt != '1) still_cnt++;
      end else begin
        still_cnt = '0;
        stable_q  = 1'b0;
      end
      if (still_cnt > limit_cfg) begin
        stable_q  = 1'b1;
        settled_q = 1'b1;
      end
      // averaging uses the uncorrected sample, bias applies from the next one
      if (calib_on) begin
        for (int a = 0; a < NUM_AXES; a++) calib_acc[a] += int'(cor[a]);
        calib_cnt++;
        if (calib_cnt >= AVG_LEN) begin
          for (int a = 0; a < NUM_AXES; a++) bias_reg[a] = rate_t'(calib_acc[a] / AVG_LEN);
          bias_ok   = 1'b1;
          calib_on  = 1'b0;
          calib_cnt = 0;
        end
      end
    end
    r.cx          = cor[0];
    r.cy          = cor[1];
    r.cz          = cor[2];
    r.msum        = motion;
    r.stable      = stable_q;
    r.settled     = settled_q;
    r.bias_valid  = bias_ok;
    r.calibrating = calib_on;
    return r;
  endfunction

  function automatic rate_t jitter(input rate_t base, input int spread);
    return rate_t'(int'(base) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic flag_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Drive one item, hold it until the transfer, then record its reading
  task automatic put_item(input op_t op, input rate_t x, y, z,
                          input bit typed = 1'b0, input gyro_out_t typed_out = '0);
    gyro_out_t pred;
    while ($urandom_range(99) < idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.operation <= op;
    sample_bus.rate_x    <= x;
    sample_bus.rate_y    <= y;
    sample_bus.rate_z    <= z;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    pred = correct_and_track(op, x, y, z);
    due_readings.push_back(typed ? typed_out : pred);
  endtask

  task automatic wait_results_drained();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (due_readings.size() != 0) @(posedge clk);
  endtask

  // Register write followed by a read-back
  task automatic set_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask;
    mask    = (idx == REG_THRESH) ? APB_DATA_W'({THRESH_W{1'b1}})
                                  : APB_DATA_W'({LIMIT_W{1'b1}});
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (value & mask)) begin
      mismatches++;
      $display("%0t: register %s read expected %0d, got %0d",
               $time, idx.name(), value & mask, prdata & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_THRESH) thresh_cfg = value[THRESH_W-1:0];
    else                   limit_cfg  = value[LIMIT_W-1:0];
    @(posedge clk);
  endtask

  // Mostly calibration runs and still stretches, with bursts of full-scale noise
  task automatic run_random(input int n_items);
    int    sent;
    int    len;
    int    noise;
    int    kind;
    bit    paused;
    rate_t bx;
    rate_t by;
    rate_t bz;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      bx   = rate_t'($urandom);
      by   = rate_t'($urandom);
      bz   = rate_t'($urandom);
      if (kind < 3) begin
        put_item(OP_CALIB, rate_t'($urandom), rate_t'($urandom), rate_t'($urandom));
        len   = ($urandom_range(3) == 0) ? $urandom_range(1, AVG_LEN - 1) : AVG_LEN;
        noise = $urandom_range(40);
        repeat (len) put_item(OP_SAMPLE, jitter(bx, noise), jitter(by, noise),
                              jitter(bz, noise));
        sent += len + 1;
      end else if (kind < 8) begin
        len   = $urandom_range(5, 40);
        noise = ($urandom_range(4) == 0) ? $urandom_range(4, 60) : $urandom_range(3);
        repeat (len) put_item(OP_SAMPLE, jitter(bx, noise), jitter(by, noise),
                              jitter(bz, noise));
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len)
          put_item(($urandom_range(7) == 0) ? OP_CALIB : OP_SAMPLE, rate_t'($urandom),
                   rate_t'($urandom), rate_t'($urandom));
        sent += len;
      end
      // hold off the sender once until the pipeline is empty
      if (!paused && sent >= n_items / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver back-pressure
  always @(posedge clk) result_bus.ready <= ($urandom_range(99) >= stall_pct);

  // Result checking and transfer watchdog
  always @(posedge clk) begin
    gyro_out_t want;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (due_readings.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no reading outstanding", $time);
        end else begin
          want = due_readings.pop_front();
          flag_field("corrected_x", want.cx, result_bus.corrected_x);
          flag_field("corrected_y", want.cy, result_bus.corrected_y);
          flag_field("corrected_z", want.cz, result_bus.corrected_z);
          flag_field("motion_sum", want.msum, result_bus.motion_sum);
          flag_field("stable", want.stable, result_bus.stable);
          flag_field("settled_once", want.settled, result_bus.settled_once);
          flag_field("bias_valid", want.bias_valid, result_bus.bias_valid);
          flag_field("calibrating", want.calibrating, result_bus.calibrating);
        end
      end
      if ((result_bus.valid && result_bus.ready) || (sample_bus.valid && sample_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    phase_t plan [5];
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    sample_bus.valid     = 1'b0;
    sample_bus.operation = OP_SAMPLE;
    sample_bus.rate_x    = '0;
    sample_bus.rate_y    = '0;
    sample_bus.rate_z    = '0;

    // reset config: threshold 20, still limit 100
    directed_rows = '{
      '{OP_SAMPLE, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{OP_SAMPLE, 32767, -32768, 32767, 1'b1, '{32767, -32768, 32767, 98302, 0, 0, 0, 0}},
      '{OP_SAMPLE, -32768, 32767, -32768, 1'b1,
        '{-32768, 32767, -32768, 196605, 0, 0, 0, 0}},
      '{OP_SAMPLE, -32768, 32767, -32768, 1'b1, '{-32768, 32767, -32768, 0, 0, 0, 0, 0}},
      // calibration start: zeroed reading, axis fields ignored
      '{OP_CALIB, 32767, -32768, -1, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1}},
      '{OP_SAMPLE, 10, -10, 0, 1'b0, '0},
      '{OP_SAMPLE, 32767, 32767, 32767, 1'b0, '0},
      // restart while averaging
      '{OP_CALIB, -1, 0, 32767, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 1}},
      '{OP_SAMPLE, -32768, -32768, -32768, 1'b0, '0},
      '{OP_SAMPLE, 1, 2, 3, 1'b0, '0},
      '{OP_SAMPLE, 1, 2, 3, 1'b0, '0}
    };

    plan[0] = '{0, 0, 196605, 65534, 60};
    plan[1] = '{0, 0, 0, 65535, 150};
    plan[2] = '{50, 0, $urandom_range(25, 60), 0, 180};
    plan[3] = '{0, 50, $urandom_range(400), $urandom_range(40), 180};
    plan[4] = '{17, 17, $urandom_range(10, 200), $urandom_range(1, 20), 180};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      put_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
               directed_rows[i].z, directed_rows[i].typed, directed_rows[i].want);
    wait_results_drained();

    foreach (plan[p]) begin
      idle_pct  = plan[p].idle_pct;
      stall_pct = plan[p].stall_pct;
      set_reg(REG_THRESH, plan[p].thresh);
      set_reg(REG_LIMIT, plan[p].limit);
      run_random(plan[p].n_items);
      wait_results_drained();
    end

    repeat (20) @(posedge clk);
    if (due_readings.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
